FILE: hw/rtl/lirs_pkg.sv
package lirs_pkg;

   localparam int PHASE_BITS_DEFAULT   = 16;
   localparam int MAX_UPSAMPLE_DEFAULT = 16;

   localparam int SAMPLE_W = 32;
   localparam int STEP_W   = 24;
   localparam int GAIN_W   = 16;
   localparam int FMT_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
   localparam logic [STEP_W-1:0] STEP_UNITY = 24'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_RATIO  = 2'd0,
      REG_GAIN_FACTOR = 2'd1,
      REG_IN_FORMAT   = 2'd2,
      REG_OUT_FORMAT  = 2'd3
   } csr_index_type;

   typedef enum logic [FMT_W-1:0] {
      FMT_Q31   = 3'd0,
      FMT_INT32 = 3'd1,
      FMT_INT16 = 3'd2,
      FMT_INT8  = 3'd3,
      FMT_UINT8 = 3'd4
   } fmt_type;

   localparam logic [FMT_W-1:0] FMT_RESET = FMT_Q31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MULT,
      ST_INTERP,
      ST_GAIN,
      ST_CONV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_cur;
      logic mult;
      logic interp;
      logic gain;
      logic conv;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic unity;
      logic phase_ge_one;
      logic last;
   } status_type;

endpackage

FILE: hw/rtl/lirs_ctrl.sv
module lirs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lirs_pkg::status_type   status,
   output lirs_pkg::cmd_type      cmd
);

   lirs_pkg::state_type state_ff;
   lirs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lirs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lirs_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lirs_pkg::ST_CHECK;
            end
         end
         lirs_pkg::ST_CHECK: begin
            if (status.unity) begin
               state_in = lirs_pkg::ST_INTERP;
            end else if (status.phase_ge_one) begin
               state_in = lirs_pkg::ST_IDLE;
            end else begin
               state_in = lirs_pkg::ST_MULT;
            end
         end
         lirs_pkg::ST_MULT:   state_in = lirs_pkg::ST_INTERP;
         lirs_pkg::ST_INTERP: state_in = lirs_pkg::ST_GAIN;
         lirs_pkg::ST_GAIN:   state_in = lirs_pkg::ST_CONV;
         lirs_pkg::ST_CONV:   state_in = lirs_pkg::ST_OUT;
         lirs_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = status.last ? lirs_pkg::ST_IDLE : lirs_pkg::ST_MULT;
            end
         end
         default: state_in = lirs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         lirs_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_cur = req_valid;
         end
         lirs_pkg::ST_CHECK: begin
            cmd.finish = !status.unity && status.phase_ge_one;
         end
         lirs_pkg::ST_MULT:   cmd.mult   = 1'b1;
         lirs_pkg::ST_INTERP: cmd.interp = 1'b1;
         lirs_pkg::ST_GAIN:   cmd.gain   = 1'b1;
         lirs_pkg::ST_CONV:   cmd.conv   = 1'b1;
         lirs_pkg::ST_OUT: begin
            rsp_valid  = 1'b1;
            cmd.finish = !rsp_stall && status.last && !status.unity;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/lirs_dp.sv
module lirs_dp #(
   parameter int PHASE_BITS   = lirs_pkg::PHASE_BITS_DEFAULT,
   parameter int MAX_UPSAMPLE = lirs_pkg::MAX_UPSAMPLE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [lirs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lirs_pkg::STEP_W-1:0]          csr_wr_data,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_sample_in,
   input  lirs_pkg::cmd_type                    cmd,
   output lirs_pkg::status_type                 status,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_last_of_run
);

   localparam int SW  = PHASE_BITS + 8;
   localparam int PW  = PHASE_BITS + 9;
   localparam int CW  = $clog2(MAX_UPSAMPLE + 1);
   localparam int PRW = PHASE_BITS + 34;
   localparam int MIN_STEP_I = ((1 << PHASE_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
   localparam logic [PW-1:0] PH_ONE   = {{(PW-1){1'b0}}, 1'b1} << PHASE_BITS;
   localparam logic [SW-1:0] MIN_STEP = SW'(MIN_STEP_I);
   localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_UPSAMPLE);

   // configuration
   logic [lirs_pkg::STEP_W-1:0] step_ratio_ff;
   logic [lirs_pkg::GAIN_W-1:0] gain_ff;
   logic [lirs_pkg::FMT_W-1:0]  in_fmt_ff;
   logic [lirs_pkg::FMT_W-1:0]  out_fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ratio_ff <= lirs_pkg::STEP_RESET;
         gain_ff       <= lirs_pkg::GAIN_RESET;
         in_fmt_ff     <= lirs_pkg::FMT_RESET;
         out_fmt_ff    <= lirs_pkg::FMT_RESET;
      end else if (csr_wr_en) begin
         case (lirs_pkg::csr_index_type'(csr_index))
            lirs_pkg::REG_STEP_RATIO:  step_ratio_ff <= csr_wr_data;
            lirs_pkg::REG_GAIN_FACTOR: gain_ff <= csr_wr_data[lirs_pkg::GAIN_W-1:0];
            lirs_pkg::REG_IN_FORMAT:   in_fmt_ff <= csr_wr_data[lirs_pkg::FMT_W-1:0];
            lirs_pkg::REG_OUT_FORMAT:  out_fmt_ff <= csr_wr_data[lirs_pkg::FMT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // step rescaled to PHASE_BITS fraction bits, raised to the minimum
   logic [PHASE_BITS+23:0] step_wide;
   logic [SW-1:0]          step_scaled;
   logic [SW-1:0]          step_eff;
   logic                   is_unity;

   assign step_wide   = {{PHASE_BITS{1'b0}}, step_ratio_ff} << PHASE_BITS;
   assign step_scaled = step_wide[PHASE_BITS+23:16];
   assign step_eff    = (step_scaled < MIN_STEP) ? MIN_STEP : step_scaled;
   assign is_unity    = (step_ratio_ff == lirs_pkg::STEP_UNITY);

   // input normalisation to Q1.31
   logic signed [31:0] norm_in;

   always_comb begin
      case (lirs_pkg::fmt_type'(in_fmt_ff))
         lirs_pkg::FMT_INT16: norm_in = {req_sample_in[15:0], 16'b0};
         lirs_pkg::FMT_INT8:  norm_in = {req_sample_in[7:0], 24'b0};
         lirs_pkg::FMT_UINT8: norm_in = {~req_sample_in[7], req_sample_in[6:0], 24'b0};
         default:             norm_in = req_sample_in;
      endcase
   end

   // state and working registers
   logic signed [31:0]     cur_ff;
   logic signed [31:0]     prev_ff;
   logic [PW-1:0]          phase_ff;
   logic [CW-1:0]          cnt_ff;
   logic signed [PRW-1:0]  prod_ff;
   logic signed [31:0]     interp_ff;
   logic signed [48:0]     gprod_ff;
   logic signed [31:0]     out_ff;
   logic                   last_ff;

   logic signed [32:0]     diff;
   logic signed [PHASE_BITS:0] phase_mul;
   logic signed [32:0]     interp_sum;
   logic [PW-1:0]          phase_sum;
   logic [CW-1:0]          cnt_inc;
   logic                   phase_ge_one;

   assign diff       = {cur_ff[31], cur_ff} - {prev_ff[31], prev_ff};
   assign phase_mul  = $signed({1'b0, phase_ff[PHASE_BITS-1:0]});
   assign interp_sum = {prev_ff[31], prev_ff} + $signed(prod_ff[PHASE_BITS+32:PHASE_BITS]);
   assign phase_sum  = phase_ff + {1'b0, step_eff};
   assign cnt_inc    = cnt_ff + CW'(1);
   assign phase_ge_one = (phase_ff >= PH_ONE);

   // output conversion: round, scale down and clamp
   logic signed [49:0] rounded;
   logic signed [35:0] scaled;
   logic signed [19:0] t16;
   logic signed [11:0] t8;
   logic signed [12:0] u8;
   logic signed [31:0] conv_out;

   assign rounded = {gprod_ff[48], gprod_ff} + 50'sd8192;
   assign scaled  = $signed(rounded[49:14]);
   assign t16     = $signed(scaled[35:16]);
   assign t8      = $signed(scaled[35:24]);
   assign u8      = {t8[11], t8} + 13'sd128;

   always_comb begin
      case (lirs_pkg::fmt_type'(out_fmt_ff))
         lirs_pkg::FMT_INT16: begin
            if (t16 > 20'sd32767) begin
               conv_out = 32'sd32767;
            end else if (t16 < -20'sd32768) begin
               conv_out = -32'sd32768;
            end else begin
               conv_out = {{12{t16[19]}}, t16};
            end
         end
         lirs_pkg::FMT_INT8: begin
            if (t8 > 12'sd127) begin
               conv_out = 32'sd127;
            end else if (t8 < -12'sd128) begin
               conv_out = -32'sd128;
            end else begin
               conv_out = {{20{t8[11]}}, t8};
            end
         end
         lirs_pkg::FMT_UINT8: begin
            if (u8 > 13'sd255) begin
               conv_out = 32'sd255;
            end else if (u8 < 13'sd0) begin
               conv_out = 32'sd0;
            end else begin
               conv_out = {24'b0, u8[7:0]};
            end
         end
         default: begin
            if (scaled > 36'sd2147483647) begin
               conv_out = 32'sh7FFFFFFF;
            end else if (scaled < -36'sd2147483648) begin
               conv_out = 32'sh80000000;
            end else begin
               conv_out = scaled[31:0];
            end
         end
      endcase
   end

   // control-visible state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         phase_ff <= '0;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         if (cmd.load_cur) begin
            cnt_ff <= '0;
         end
         if (cmd.conv) begin
            last_ff <= is_unity || (phase_sum >= PH_ONE) || (cnt_inc == CNT_MAX);
            if (!is_unity) begin
               phase_ff <= phase_sum;
               cnt_ff   <= cnt_inc;
            end
         end
         if (cmd.finish) begin
            prev_ff  <= cur_ff;
            phase_ff <= phase_ge_one ? (phase_ff - PH_ONE) : phase_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_cur) begin
         cur_ff <= norm_in;
      end
      if (cmd.mult) begin
         prod_ff <= PRW'(diff) * PRW'(phase_mul);
      end
      if (cmd.interp) begin
         interp_ff <= is_unity ? cur_ff : interp_sum[31:0];
      end
      if (cmd.gain) begin
         gprod_ff <= interp_ff * $signed({1'b0, gain_ff});
      end
      if (cmd.conv) begin
         out_ff <= conv_out;
      end
   end

   assign status.unity        = is_unity;
   assign status.phase_ge_one = phase_ge_one;
   assign status.last         = last_ff;

   assign rsp_sample_out  = out_ff;
   assign rsp_last_of_run = last_ff;

endmodule

FILE: hw/rtl/linear_interp_resampler_core.sv
// Sequence: accept, a decision step, then per result the interpolation multiply,
// add, gain multiply, round and clamp, and an output beat that holds while the
// output side stalls. A skipped input goes from the decision back to idle; a
// unity-step input goes from the decision straight to the add. Reset (synchronous)
// restores the register defaults, a zero previous sample and a zero phase.
module linear_interp_resampler_core #(
   parameter int PHASE_BITS   = lirs_pkg::PHASE_BITS_DEFAULT,
   parameter int MAX_UPSAMPLE = lirs_pkg::MAX_UPSAMPLE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel: one sample per beat
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_sample_in,
   // result channel: up to MAX_UPSAMPLE beats per input
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_last_of_run,
   // register writes, which the user must make only while idle; the block does not enforce this
   input  logic                                 csr_wr_en,
   input  logic [lirs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lirs_pkg::STEP_W-1:0]          csr_wr_data
);

   lirs_pkg::cmd_type    cmd;
   lirs_pkg::status_type status;

   // Sequencer: hold the input side stalled from acceptance until the last
   // result beat of that sample has left, and drop skipped samples straight
   // into the previous-sample register.
   lirs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: normalise the sample, interpolate between the previous and
   // current sample at the running phase, apply the gain, convert and clamp.
   // Advance the phase by the step after each result, except at unity step.
   lirs_dp #(
      .PHASE_BITS   (PHASE_BITS),
      .MAX_UPSAMPLE (MAX_UPSAMPLE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_sample_in   (req_sample_in),
      .cmd             (cmd),
      .status          (status),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
